// ===== hw/rtl/sppk_pkg.sv =====
// Shared types and constants for the spectral peak picker.
package sppk_pkg;

   localparam int MAG_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int BIN_W    = 10;
   localparam int CNT_W    = 11;
   localparam int HZ_W     = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 88;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_BIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK_MAG = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PEAKS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HZ       = 3'd4;

   localparam logic [BIN_W-1:0] MIN_FIRST_BIN = 10'd2;
   localparam logic [CNT_W-1:0] COUNTER_MAX   = 11'd2047;

   // 1.5*pi and 2*pi in Q12
   localparam logic signed [16:0] PHASE_WRAP_LIMIT = 17'sd19301;
   localparam logic signed [17:0] PHASE_TWO_PI     = 18'sd25736;

   localparam logic KIND_PEAK    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [BIN_W-1:0]          first_bin;
      logic [BIN_W-1:0]          last_bin;
      logic signed [MAG_W-1:0]   min_peak_mag;
      logic [CNT_W-1:0]          max_peaks;
      logic [HZ_W-1:0]           bin_hz;
   } cfg_type;

   typedef struct packed {
      logic                      has_peak;
      logic                      has_sum;
      logic [CNT_W-1:0]          total;
      logic [BIN_W-1:0]          c;
      logic signed [MAG_W-1:0]   mag_l;
      logic signed [MAG_W-1:0]   mag_m;
      logic signed [MAG_W-1:0]   mag_r;
      logic signed [PHASE_W-1:0] ph_l;
      logic signed [PHASE_W-1:0] ph_c;
      logic signed [PHASE_W-1:0] ph_r;
   } job_type;

endpackage

// ===== hw/rtl/sppk_front.sv =====
// Front end: bin window, peak detection and job issue.
module sppk_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sppk_pkg::cfg_type                     cfg,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sppk_pkg::REQ_DATA_W-1:0]       req_tdata,  // magnitude, phase
   input  logic                                  req_tlast,  // frame_end
   input  logic                                  q_full,
   output logic                                  q_push,
   output sppk_pkg::job_type                     q_job
);
   import sppk_pkg::*;

   logic signed [MAG_W-1:0]   mag_win_ff [2];
   logic signed [MAG_W-1:0]   mag_win_in [2];
   logic signed [PHASE_W-1:0] ph_win_ff [2];
   logic signed [PHASE_W-1:0] ph_win_in [2];
   logic [CNT_W-1:0]          bin_cnt_ff, bin_cnt_in;
   logic [CNT_W-1:0]          peaks_ff, peaks_in;

   logic                      accept;
   logic signed [MAG_W-1:0]   new_mag;
   logic signed [PHASE_W-1:0] new_ph;
   logic [BIN_W-1:0]          lo_bin;
   logic [CNT_W-1:0]          c;
   logic                      is_peak;
   logic [CNT_W-1:0]          peaks_inc;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign new_mag    = $signed(req_tdata[MAG_W-1:0]);
   assign new_ph     = $signed(req_tdata[MAG_W +: PHASE_W]);
   assign lo_bin     = (cfg.first_bin < MIN_FIRST_BIN) ? MIN_FIRST_BIN : cfg.first_bin;
   assign c          = bin_cnt_ff - 11'd1;

   // window holds c-1 and c; the incoming bin is the right neighbor
   assign is_peak = (bin_cnt_ff != '0) && (c >= {1'b0, lo_bin}) &&
                    (c <= {1'b0, cfg.last_bin}) && (peaks_ff < cfg.max_peaks) &&
                    (mag_win_ff[1] > cfg.min_peak_mag) &&
                    (mag_win_ff[1] >= mag_win_ff[0]) && (mag_win_ff[1] >= new_mag) &&
                    (mag_win_ff[0] > 0) && (new_mag > 0);

   assign peaks_inc = (is_peak && peaks_ff != COUNTER_MAX) ? peaks_ff + 11'd1 : peaks_ff;

   always_comb begin
      q_job.has_peak = is_peak;
      q_job.has_sum  = req_tlast;
      q_job.total    = peaks_inc;
      q_job.c        = c[BIN_W-1:0];
      q_job.mag_l    = mag_win_ff[0];
      q_job.mag_m    = mag_win_ff[1];
      q_job.mag_r    = new_mag;
      q_job.ph_l     = ph_win_ff[0];
      q_job.ph_c     = ph_win_ff[1];
      q_job.ph_r     = new_ph;
   end

   assign q_push = accept && (is_peak || req_tlast);

   always_comb begin
      mag_win_in = mag_win_ff;
      ph_win_in  = ph_win_ff;
      bin_cnt_in = bin_cnt_ff;
      peaks_in   = peaks_ff;
      if (accept) begin
         if (req_tlast) begin
            mag_win_in[0] = '0;
            mag_win_in[1] = '0;
            ph_win_in[0]  = '0;
            ph_win_in[1]  = '0;
            bin_cnt_in    = '0;
            peaks_in      = '0;
         end else begin
            mag_win_in[0] = mag_win_ff[1];
            mag_win_in[1] = new_mag;
            ph_win_in[0]  = ph_win_ff[1];
            ph_win_in[1]  = new_ph;
            bin_cnt_in    = (bin_cnt_ff != COUNTER_MAX) ? bin_cnt_ff + 11'd1 : bin_cnt_ff;
            peaks_in      = peaks_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_win_ff[0] <= '0;
         mag_win_ff[1] <= '0;
         ph_win_ff[0]  <= '0;
         ph_win_ff[1]  <= '0;
         bin_cnt_ff    <= '0;
         peaks_ff      <= '0;
      end else begin
         mag_win_ff <= mag_win_in;
         ph_win_ff  <= ph_win_in;
         bin_cnt_ff <= bin_cnt_in;
         peaks_ff   <= peaks_in;
      end
   end

endmodule

// ===== hw/rtl/sppk_queue.sv =====
// Short job queue between the front end and the interpolation engine.
module sppk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sppk_pkg::job_type din,
   input  logic              pop,
   output sppk_pkg::job_type dout,
   output logic              full,
   output logic              empty
);
   import sppk_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("pop from empty queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");

endmodule

// ===== hw/rtl/sppk_back.sv =====
// Back end: parabolic interpolation, frequency and phase, result register.
module sppk_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sppk_pkg::HZ_W-1:0]       bin_hz,
   input  logic                            q_empty,
   input  sppk_pkg::job_type               q_job,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // peak_freq[19:0], peak_mag[35:20], peak_position[57:36],
   // peak_phase[74:58], peak_total[85:75], zero fill
   output logic [sppk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,  // kind
   output logic                            rsp_tlast
);
   import sppk_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_PREP    = 10'b00_0000_0010,
      ST_DIV_OFF = 10'b00_0000_0100,
      ST_DIV_MAG = 10'b00_0000_1000,
      ST_POS     = 10'b00_0001_0000,
      ST_MUL_LO  = 10'b00_0010_0000,
      ST_MUL_HI  = 10'b00_0100_0000,
      ST_PH_MUL  = 10'b00_1000_0000,
      ST_PEAK    = 10'b01_0000_0000,
      ST_SUM     = 10'b10_0000_0000
   } back_state_type;

   back_state_type       state_ff, state_in;
   job_type              job_ff, job_in;
   logic [16:0]          d_ff, d_in;
   logic [33:0]          sq_ff, sq_in;
   logic                 neg_ff, neg_in;
   logic signed [12:0]   off_ff, off_in;
   logic [14:0]          magq_ff, magq_in;
   logic [33:0]          dvd_ff, dvd_in;
   logic [20:0]          rem_ff, rem_in;
   logic [19:0]          dvs_ff, dvs_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [21:0]          pos_ff, pos_in;
   logic signed [17:0]   lp_ff, lp_in;
   logic signed [18:0]   dd_ff, dd_in;
   logic [12:0]          fr_ff, fr_in;
   logic [35:0]          plo_ff, plo_in;
   logic [35:0]          phi_ff, phi_in;
   logic signed [32:0]   pt_ff, pt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                 out_kind_ff, out_kind_in;
   logic                 out_last_ff, out_last_in;

   // restoring divider step
   logic [20:0]          rem_sh, rem_nx;
   logic                 ge;
   logic [33:0]          dvd_nx;

   // prep terms
   logic signed [18:0]   d_full;
   logic signed [16:0]   dr;
   logic [16:0]          adr, diff;
   logic [12:0]          q_off;

   // position and phase terms
   logic signed [15:0]   lp_sel, rp_sel;
   logic signed [17:0]   lp_w, rp_w;
   logic signed [16:0]   ph_dif;

   // result terms
   logic [49:0]          fprod;
   logic [25:0]          fq;
   logic [19:0]          freq;
   logic [32:0]          apt;
   logic [20:0]          rq;
   logic signed [21:0]   ph_sum;
   logic signed [16:0]   ph_out;
   logic signed [17:0]   mag_sum;
   logic signed [15:0]   mag_out;
   logic                 out_free;

   assign rem_sh = {rem_ff[19:0], dvd_ff[33]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});
   assign rem_nx = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
   assign dvd_nx = {dvd_ff[32:0], ge};

   assign d_full = 19'(2 * job_ff.mag_m) - 19'(job_ff.mag_l) - 19'(job_ff.mag_r);
   assign dr     = 17'(job_ff.mag_r) - 17'(job_ff.mag_l);
   assign adr    = dr[16] ? 17'(-dr) : 17'(dr);
   assign diff   = adr;
   assign q_off  = {1'b0, dvd_nx[11:0]};

   assign lp_sel = (off_ff >= 0) ? job_ff.ph_c : job_ff.ph_l;
   assign rp_sel = (off_ff >= 0) ? job_ff.ph_r : job_ff.ph_c;
   assign ph_dif = 17'(lp_sel) - 17'(rp_sel);

   always_comb begin
      lp_w = 18'(lp_sel);
      rp_w = 18'(rp_sel);
      if (ph_dif > PHASE_WRAP_LIMIT) rp_w = 18'(rp_sel) + PHASE_TWO_PI;
      else if (-ph_dif > PHASE_WRAP_LIMIT) lp_w = 18'(lp_sel) + PHASE_TWO_PI;
   end

   // frequency: round(pos * bin_hz / 2^24), partial products formed in ST_MUL_LO and ST_MUL_HI
   assign fprod = {phi_ff, 14'b0} + {14'b0, plo_ff} + 50'd8388608;
   assign fq    = fprod[49:24];
   assign freq  = (fq > 26'hFFFFF) ? 20'hFFFFF : fq[19:0];

   assign apt    = pt_ff[32] ? 33'(-pt_ff) : 33'(pt_ff);
   assign rq     = 21'((apt + 33'd2048) >> 12);
   assign ph_sum = 22'(lp_ff) + (pt_ff[32] ? -22'(rq) : 22'(rq));
   assign ph_out = (ph_sum > 22'sd65535) ? 17'sd65535 :
                   (ph_sum < -22'sd65536) ? -17'sd65536 : 17'(ph_sum);

   assign mag_sum = 18'(job_ff.mag_m) + 18'(magq_ff);
   assign mag_out = (mag_sum > 18'sd32767) ? 16'sd32767 :
                    (mag_sum < -18'sd32768) ? -16'sd32768 : 16'(mag_sum);

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      neg_in       = neg_ff;
      off_in       = off_ff;
      magq_in      = magq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      lp_in        = lp_ff;
      dd_in        = dd_ff;
      fr_in        = fr_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      pt_in        = pt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = q_job.has_peak ? ST_PREP : ST_SUM;
            end
         end
         ST_PREP: begin
            d_in   = d_full[16:0];
            sq_in  = diff * diff;
            neg_in = dr[16];
            dvd_in = {6'b0, adr, 11'b0} + {17'b0, d_full[16:1]};
            dvs_in = {3'b0, d_full[16:0]};
            rem_in = '0;
            cnt_in = 6'd33;
            if (d_full == '0) begin
               off_in   = '0;
               magq_in  = '0;
               state_in = ST_POS;
            end else begin
               state_in = ST_DIV_OFF;
            end
         end
         ST_DIV_OFF: begin
            rem_in = rem_nx;
            dvd_in = dvd_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               off_in   = neg_ff ? -$signed(q_off) : $signed(q_off);
               dvd_in   = sq_ff + {15'b0, d_ff, 2'b0};
               dvs_in   = {d_ff, 3'b0};
               rem_in   = '0;
               cnt_in   = 6'd33;
               state_in = ST_DIV_MAG;
            end
         end
         ST_DIV_MAG: begin
            rem_in = rem_nx;
            dvd_in = dvd_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               magq_in  = dvd_nx[14:0];
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            pos_in   = {job_ff.c, 12'b0} + 22'(off_ff);
            fr_in    = (off_ff >= 0) ? 13'(off_ff) : 13'(14'sd4096 + 14'(off_ff));
            lp_in    = lp_w;
            dd_in    = 19'(rp_w) - 19'(lp_w);
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            plo_in   = pos_ff * bin_hz[13:0];
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            phi_in   = pos_ff * bin_hz[27:14];
            state_in = ST_PH_MUL;
         end
         ST_PH_MUL: begin
            pt_in    = 33'($signed({1'b0, fr_ff}) * dd_ff);
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_PEAK;
               out_last_in  = !job_ff.has_sum;
               out_data_in  = {2'b0, 11'b0, ph_out, pos_ff, mag_out, freq};
               state_in     = job_ff.has_sum ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_SUMMARY;
               out_last_in  = 1'b1;
               out_data_in  = {2'b0, job_ff.total, 75'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      neg_ff      <= neg_in;
      off_ff      <= off_in;
      magq_ff     <= magq_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      lp_ff       <= lp_in;
      dd_ff       <= dd_in;
      fr_ff       <= fr_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      pt_ff       <= pt_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE)) else $error("pop outside idle");
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY) |-> rsp_tlast)
      else $error("summary beat without last");
   a_peak_to_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEAK && out_free && job_ff.has_sum) |=> (state_ff == ST_SUM))
      else $error("summary skipped after peak");

endmodule

// ===== hw/rtl/spectral_peak_picker_core.sv =====
// Spectral peak picker top level: config registers, front end, queue, back end.
// Throughput: one bin beat per cycle while the job queue has room.
// Peak beats pass through the two 34-step serial divisions in the back end,
// skipped when the parabola is flat; summary beats bypass them.
// Peaks queue up (four jobs); the front end stalls only when the queue is full.
// Reset (synchronous, active high) clears the window, counters, queue and
// restores the register defaults.
module spectral_peak_picker_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sppk_pkg::REQ_DATA_W-1:0]       req_tdata,  // magnitude[15:0], phase[31:16]
   input  logic                                  req_tlast,  // frame_end
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // peak_freq[19:0], peak_mag[35:20], peak_position[57:36],
   // peak_phase[74:58], peak_total[85:75], zero fill
   output logic [sppk_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,  // kind
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [sppk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sppk_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sppk_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_full, q_empty, q_push, q_pop;
   job_type  q_din, q_dout;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_BIN:    cfg_in.first_bin    = csr_wdata[BIN_W-1:0];
            CSR_LAST_BIN:     cfg_in.last_bin     = csr_wdata[BIN_W-1:0];
            CSR_MIN_PEAK_MAG: cfg_in.min_peak_mag = $signed(csr_wdata[MAG_W-1:0]);
            CSR_MAX_PEAKS:    cfg_in.max_peaks    = csr_wdata[CNT_W-1:0];
            CSR_BIN_HZ:       cfg_in.bin_hz       = csr_wdata[HZ_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bin    <= 10'd2;
         cfg_ff.last_bin     <= 10'd1023;
         cfg_ff.min_peak_mag <= '0;
         cfg_ff.max_peaks    <= 11'd100;
         cfg_ff.bin_hz       <= 28'd1536000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sppk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_din)
   );

   sppk_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   sppk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .bin_hz     (cfg_ff.bin_hz),
      .q_empty    (q_empty),
      .q_job      (q_dout),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
